@@ rtl/integer_alu_with_status_flags_unit_macros.svh @@
`ifndef INTEGER_ALU_WITH_STATUS_FLAGS_UNIT_MACROS_SVH
`define INTEGER_ALU_WITH_STATUS_FLAGS_UNIT_MACROS_SVH

// property checked on every edge out of reset
`define IALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal holds while the condition stands
`define IALU_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ rtl/ialu_pkg.sv @@
package ialu_pkg;

  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 4;
  localparam int FLAGS_W = 12;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD  = 4'd0,
    FUNC_SUB  = 4'd1,
    FUNC_AND  = 4'd2,
    FUNC_XOR  = 4'd3,
    FUNC_CMP  = 4'd4,
    FUNC_TEST = 4'd5,
    FUNC_INC  = 4'd6,
    FUNC_DEC  = 4'd7,
    FUNC_SAR  = 4'd8
  } func_t;

  localparam int CF_BIT = 0;
  localparam int PF_BIT = 2;
  localparam int AF_BIT = 4;
  localparam int ZF_BIT = 6;
  localparam int SF_BIT = 7;
  localparam int OF_BIT = 11;

  localparam logic [FLAGS_W-1:0] FLAGS_RESET = 12'h246;
  localparam logic [DATA_W-1:0]  BYTE_MASK   = 32'h0000_00ff;
  localparam logic [DATA_W-1:0]  DWORD_SIGN  = 32'h8000_0000;

endpackage

@@ rtl/ialu_in_if.sv @@
interface ialu_in_if;
  logic                           valid;
  logic                           ready;
  logic [ialu_pkg::FUNC_W-1:0]    func;
  logic                           is_dword;
  logic [ialu_pkg::DATA_W-1:0]    operand_a;
  logic [ialu_pkg::DATA_W-1:0]    operand_b;

  modport source(output valid, func, is_dword, operand_a, operand_b, input ready);
  modport sink(input valid, func, is_dword, operand_a, operand_b, output ready);
endinterface

@@ rtl/ialu_out_if.sv @@
interface ialu_out_if;
  logic                           valid;
  logic                           ready;
  logic [ialu_pkg::DATA_W-1:0]    result;
  logic                           writes_back;
  logic [ialu_pkg::FLAGS_W-1:0]   flags;

  modport source(output valid, result, writes_back, flags, input ready);
  modport sink(input valid, result, writes_back, flags, output ready);
endinterface

@@ rtl/ialu_core.sv @@
module ialu_core (
  input  logic [ialu_pkg::FUNC_W-1:0]  func,
  input  logic                         is_dword,
  input  logic [ialu_pkg::DATA_W-1:0]  operand_a,
  input  logic [ialu_pkg::DATA_W-1:0]  operand_b,
  input  logic [ialu_pkg::FLAGS_W-1:0] flags_in,
  output logic [ialu_pkg::DATA_W-1:0]  result,
  output logic                         writes_back,
  output logic [ialu_pkg::FLAGS_W-1:0] flags_out
);

  logic [ialu_pkg::DATA_W-1:0] wmask;
  logic [ialu_pkg::DATA_W-1:0] a;
  logic [ialu_pkg::DATA_W-1:0] b;
  logic [ialu_pkg::DATA_W-1:0] b_one;
  logic [ialu_pkg::DATA_W:0]   sum;
  logic [ialu_pkg::DATA_W:0]   diff;
  logic [ialu_pkg::DATA_W-1:0] sum_w;
  logic [ialu_pkg::DATA_W-1:0] diff_w;
  logic [ialu_pkg::DATA_W-1:0] ext;
  logic [ialu_pkg::DATA_W-1:0] sar_w;
  logic [4:0]                  cnt;
  logic [4:0]                  cnt_m1;
  logic                        sa, sb, sr;
  logic [ialu_pkg::DATA_W-1:0] r;
  logic                        use_one;

  assign wmask   = is_dword ? '1 : ialu_pkg::BYTE_MASK;
  assign a       = operand_a & wmask;
  assign b       = operand_b & wmask;
  assign use_one = (func == ialu_pkg::FUNC_INC) || (func == ialu_pkg::FUNC_DEC);
  assign b_one   = use_one ? ialu_pkg::DATA_W'(1) : b;

  // one adder and one subtractor shared by the arithmetic codes
  assign sum    = {1'b0, a} + {1'b0, b_one};
  assign diff   = {1'b0, a} - {1'b0, b_one};
  assign sum_w  = sum[ialu_pkg::DATA_W-1:0] & wmask;
  assign diff_w = diff[ialu_pkg::DATA_W-1:0] & wmask;

  // byte operands are sign extended so one arithmetic shifter serves both sizes
  assign ext    = is_dword ? a : {{(ialu_pkg::DATA_W-8){a[7]}}, a[7:0]};
  assign cnt    = operand_b[4:0];
  assign cnt_m1 = cnt - 5'd1;
  assign sar_w  = $unsigned($signed(ext) >>> cnt) & wmask;

  assign sa = is_dword ? a[ialu_pkg::DATA_W-1] : a[7];
  assign sb = is_dword ? b_one[ialu_pkg::DATA_W-1] : b_one[7];

  always_comb begin
    r           = a;
    writes_back = 1'b0;
    flags_out   = flags_in;
    sr          = 1'b0;
    case (ialu_pkg::func_t'(func))
      ialu_pkg::FUNC_ADD, ialu_pkg::FUNC_INC: begin
        r           = sum_w;
        sr          = is_dword ? r[ialu_pkg::DATA_W-1] : r[7];
        writes_back = 1'b1;
        if (func == ialu_pkg::FUNC_ADD) begin
          flags_out[ialu_pkg::CF_BIT] = is_dword ? sum[ialu_pkg::DATA_W] : sum[8];
        end
        flags_out[ialu_pkg::OF_BIT] = ~(sa ^ sb) & (sa ^ sr);
        flags_out[ialu_pkg::PF_BIT] = ~^r[7:0];
        flags_out[ialu_pkg::ZF_BIT] = (r == '0);
        flags_out[ialu_pkg::SF_BIT] = sr;
      end
      ialu_pkg::FUNC_SUB, ialu_pkg::FUNC_CMP, ialu_pkg::FUNC_DEC: begin
        r           = diff_w;
        sr          = is_dword ? r[ialu_pkg::DATA_W-1] : r[7];
        writes_back = (func != ialu_pkg::FUNC_CMP);
        // masked operands, so the top bit is the borrow at either size
        if (func != ialu_pkg::FUNC_DEC) begin
          flags_out[ialu_pkg::CF_BIT] = diff[ialu_pkg::DATA_W];
        end
        flags_out[ialu_pkg::OF_BIT] = (sa ^ sb) & (sa ^ sr);
        flags_out[ialu_pkg::PF_BIT] = ~^r[7:0];
        flags_out[ialu_pkg::ZF_BIT] = (r == '0);
        flags_out[ialu_pkg::SF_BIT] = sr;
      end
      ialu_pkg::FUNC_AND, ialu_pkg::FUNC_XOR, ialu_pkg::FUNC_TEST: begin
        r           = (func == ialu_pkg::FUNC_XOR) ? (a ^ b) : (a & b);
        sr          = is_dword ? r[ialu_pkg::DATA_W-1] : r[7];
        writes_back = (func != ialu_pkg::FUNC_TEST);
        flags_out[ialu_pkg::CF_BIT] = 1'b0;
        flags_out[ialu_pkg::OF_BIT] = 1'b0;
        flags_out[ialu_pkg::PF_BIT] = ~^r[7:0];
        flags_out[ialu_pkg::ZF_BIT] = (r == '0);
        flags_out[ialu_pkg::SF_BIT] = sr;
      end
      ialu_pkg::FUNC_SAR: begin
        writes_back = 1'b1;
        // zero count passes the operand through, flags untouched
        if (cnt != 5'd0) begin
          r = sar_w;
          flags_out[ialu_pkg::CF_BIT] = ext[cnt_m1];
          if (cnt == 5'd1) begin
            flags_out[ialu_pkg::OF_BIT] = 1'b0;
          end
        end
      end
      default: begin
        r           = a;
        writes_back = 1'b0;
      end
    endcase
    result = r;
  end

endmodule

@@ rtl/integer_alu_with_status_flags_unit.sv @@
// Integer ALU with x86 status flags. One word is accepted per cycle on in_ch when nothing
// stalls, and its result appears on out_ch: the operation goes through an input register,
// then the add/subtract, logic and arithmetic-shift paths and the flag update settle
// combinationally into the result register. CF, PF, ZF, SF and
// OF live in a status register (0x246 after reset) that is updated as each word moves
// into the result register, so back-to-back words see the flags of the word before.
// AF and the unnamed status bits keep their reset values. A stall on out_ch holds the
// result and backs up into the input register before in_ch.ready drops.
module integer_alu_with_status_flags_unit (
  input  logic         clk,
  input  logic         rst_n,
  ialu_in_if.sink      in_ch,
  ialu_out_if.source   out_ch
);

  logic                         s1_valid_r;
  logic [ialu_pkg::FUNC_W-1:0]  s1_func_r;
  logic                         s1_is_dword_r;
  logic [ialu_pkg::DATA_W-1:0]  s1_a_r;
  logic [ialu_pkg::DATA_W-1:0]  s1_b_r;

  logic                         out_valid_r;
  logic [ialu_pkg::DATA_W-1:0]  out_result_r;
  logic                         out_wb_r;
  logic [ialu_pkg::FLAGS_W-1:0] flags_r;

  logic                         out_free;
  logic                         s1_adv;
  logic                         in_take;
  logic [ialu_pkg::DATA_W-1:0]  result_nxt;
  logic                         wb_nxt;
  logic [ialu_pkg::FLAGS_W-1:0] flags_nxt;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  ialu_core u_core (
    .func        (s1_func_r),
    .is_dword    (s1_is_dword_r),
    .operand_a   (s1_a_r),
    .operand_b   (s1_b_r),
    .flags_in    (flags_r),
    .result      (result_nxt),
    .writes_back (wb_nxt),
    .flags_out   (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r     <= in_ch.func;
      s1_is_dword_r <= in_ch.is_dword;
      s1_a_r        <= in_ch.operand_a;
      s1_b_r        <= in_ch.operand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= ialu_pkg::FLAGS_RESET;
    end else begin
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result_r <= result_nxt;
      out_wb_r     <= wb_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result      = out_result_r;
  assign out_ch.writes_back = out_wb_r;
  assign out_ch.flags       = flags_r;

endmodule

@@ rtl/ialu_checker.sv @@
`include "integer_alu_with_status_flags_unit_macros.svh"

module ialu_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ialu_pkg::DATA_W-1:0]  out_result,
  input logic                         out_writes_back,
  input logic [ialu_pkg::FLAGS_W-1:0] out_flags
);

  // stalled word keeps its payload
  `IALU_HOLD(a_out_hold, out_valid && !out_ready, {out_result, out_writes_back, out_flags}, "result word changed while stalled")
  // af and the unnamed bits are never written
  `IALU_ASSERT(a_fixed_bits, out_valid |-> (out_flags & 12'h73a) == (ialu_pkg::FLAGS_RESET & 12'h73a), "reserved or AF flag bits moved")
  // nothing left over from before reset
  `IALU_ASSERT(a_reset_empty, !$past(rst_n) |-> !out_valid && in_ready, "pipeline not empty after reset")
  // with the result side free, the input side is never held off
  `IALU_ASSERT(a_no_block, !out_valid |-> in_ready, "input held off while result register empty")

endmodule

bind integer_alu_with_status_flags_unit ialu_checker u_ialu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result      (out_ch.result),
  .out_writes_back (out_ch.writes_back),
  .out_flags       (out_ch.flags)
);

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS   = 1250;
  localparam int DRAIN_CYCLES   = 20;

  // codes the block does not decode
  localparam logic [ialu_pkg::FUNC_W-1:0] FUNC_UNUSED_LO =
    ialu_pkg::FUNC_W'(ialu_pkg::FUNC_SAR + 1);
  localparam logic [ialu_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = '1;

  typedef struct {
    logic [ialu_pkg::FUNC_W-1:0] func;
    logic                        is_dword;
    logic [ialu_pkg::DATA_W-1:0] operand_a;
    logic [ialu_pkg::DATA_W-1:0] operand_b;
  } alu_word_t;

  typedef struct {
    logic [ialu_pkg::DATA_W-1:0]  result;
    logic                         writes_back;
    logic [ialu_pkg::FLAGS_W-1:0] flags;
  } alu_result_t;

  class flag_scoreboard;
    logic [ialu_pkg::FLAGS_W-1:0] status;
    alu_result_t                  expected_q[$];
    int                           mismatches;

    function new();
      status     = ialu_pkg::FLAGS_RESET;
      mismatches = 0;
    endfunction

    function void note_word(alu_word_t w);
      logic [ialu_pkg::DATA_W-1:0]  wmask;
      logic [ialu_pkg::DATA_W-1:0]  sign;
      logic [ialu_pkg::DATA_W-1:0]  a;
      logic [ialu_pkg::DATA_W-1:0]  b;
      logic [ialu_pkg::DATA_W-1:0]  r;
      logic [ialu_pkg::FLAGS_W-1:0] f;
      logic                         wb;
      logic                         neg;
      logic                         set_szp;
      int                           width;
      int                           cnt;
      alu_result_t                  want;
      wmask   = w.is_dword ? '1 : ialu_pkg::BYTE_MASK;
      sign    = w.is_dword ? ialu_pkg::DWORD_SIGN : 32'h80;
      width   = w.is_dword ? 32 : 8;
      a       = w.operand_a & wmask;
      b       = w.operand_b & wmask;
      f       = status;
      r       = a;
      wb      = 1'b0;
      set_szp = 1'b0;
      case (w.func)
        ialu_pkg::FUNC_ADD, ialu_pkg::FUNC_INC: begin
          if (w.func == ialu_pkg::FUNC_INC) b = ialu_pkg::DATA_W'(1);
          r = (a + b) & wmask;
          if (w.func == ialu_pkg::FUNC_ADD) f[ialu_pkg::CF_BIT] = (r < a);
          f[ialu_pkg::OF_BIT] = |(~(a ^ b) & (a ^ r) & sign);
          set_szp = 1'b1;
          wb = 1'b1;
        end
        ialu_pkg::FUNC_SUB, ialu_pkg::FUNC_CMP, ialu_pkg::FUNC_DEC: begin
          if (w.func == ialu_pkg::FUNC_DEC) b = ialu_pkg::DATA_W'(1);
          r = (a - b) & wmask;
          if (w.func != ialu_pkg::FUNC_DEC) f[ialu_pkg::CF_BIT] = (a < b);
          f[ialu_pkg::OF_BIT] = |((a ^ b) & (a ^ r) & sign);
          set_szp = 1'b1;
          wb = (w.func != ialu_pkg::FUNC_CMP);
        end
        ialu_pkg::FUNC_AND, ialu_pkg::FUNC_XOR, ialu_pkg::FUNC_TEST: begin
          r = (w.func == ialu_pkg::FUNC_XOR) ? (a ^ b) : (a & b);
          set_szp = 1'b1;
          f[ialu_pkg::CF_BIT] = 1'b0;
          f[ialu_pkg::OF_BIT] = 1'b0;
          wb = (w.func != ialu_pkg::FUNC_TEST);
        end
        ialu_pkg::FUNC_SAR: begin
          cnt = int'(w.operand_b[4:0]);
          neg = |(a & sign);
          wb  = 1'b1;
          // a zero count touches no flag
          if (cnt != 0) begin
            if (cnt < width) r = (a >> cnt) | (neg ? (wmask & ~(wmask >> cnt)) : '0);
            else r = neg ? wmask : '0;
            f[ialu_pkg::CF_BIT] = (cnt - 1 < width) ? a[cnt-1] : neg;
            if (cnt == 1) f[ialu_pkg::OF_BIT] = 1'b0;
          end
        end
        default: begin
          r  = a;
          wb = 1'b0;
        end
      endcase
      if (set_szp) begin
        f[ialu_pkg::PF_BIT] = ~^r[7:0];
        f[ialu_pkg::ZF_BIT] = (r == '0);
        f[ialu_pkg::SF_BIT] = |(r & sign);
      end
      status           = f;
      want.result      = r & wmask;
      want.writes_back = wb;
      want.flags       = f;
      expected_q.push_back(want);
    endfunction

    function void check_result(alu_result_t got);
      alu_result_t want;
      if (expected_q.size() == 0) begin
        $error("result 0x%08h arrived with no word outstanding", got.result);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.result !== want.result) begin
        $error("result: expected 0x%08h, got 0x%08h", want.result, got.result);
        mismatches++;
      end
      if (got.writes_back !== want.writes_back) begin
        $error("writes_back: expected %0b, got %0b", want.writes_back, got.writes_back);
        mismatches++;
      end
      if (got.flags !== want.flags) begin
        $error("flags: expected 0x%03h, got 0x%03h", want.flags, got.flags);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int   idle_cycles;

  flag_scoreboard sb = new();

  ialu_in_if  in_ch();
  ialu_out_if out_ch();

  integer_alu_with_status_flags_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ialu_pkg::DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ialu_pkg::DWORD_SIGN;
      3: return ialu_pkg::DWORD_SIGN - 1;
      // byte sign boundary with junk above the byte
      4: return ($urandom() & ~ialu_pkg::BYTE_MASK) |
                ialu_pkg::DATA_W'($urandom_range(126, 129));
      5: return ialu_pkg::DATA_W'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  function automatic alu_word_t rand_word();
    alu_word_t w;
    if ($urandom_range(0, 19) == 0)
      w.func = ialu_pkg::FUNC_W'($urandom_range(int'(FUNC_UNUSED_LO), int'(FUNC_UNUSED_HI)));
    else
      w.func = ialu_pkg::FUNC_W'($urandom_range(int'(ialu_pkg::FUNC_ADD),
                                                int'(ialu_pkg::FUNC_SAR)));
    w.is_dword  = 1'($urandom_range(0, 1));
    w.operand_a = rand_operand();
    w.operand_b = rand_operand();
    return w;
  endfunction

  task automatic send_word(alu_word_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid     <= 1'b0;
      in_ch.operand_a <= $urandom();
      in_ch.operand_b <= $urandom();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= w.func;
    in_ch.is_dword  <= w.is_dword;
    in_ch.operand_a <= w.operand_a;
    in_ch.operand_b <= w.operand_b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // result side back-pressure
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      n = idle_len();
      if (n > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    alu_word_t   w;
    alu_result_t got;
    logic        moved;
    moved = 1'b0;
    if (rst_n === 1'b1) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        w.func      = in_ch.func;
        w.is_dword  = in_ch.is_dword;
        w.operand_a = in_ch.operand_a;
        w.operand_b = in_ch.operand_b;
        sb.note_word(w);
        moved = 1'b1;
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.result      = out_ch.result;
        got.writes_back = out_ch.writes_back;
        got.flags       = out_ch.flags;
        sb.check_result(got);
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[integer_alu_with_status_flags_unit] ERROR");
      $finish;
    end
  end

  initial begin
    alu_word_t directed_q[$];
    in_ch.valid     = 1'b0;
    in_ch.func      = ialu_pkg::FUNC_ADD;
    in_ch.is_dword  = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    quiet           = 1'b0;
    idle_cycles     = 0;
    rst_n           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_q = '{
      '{ialu_pkg::FUNC_ADD,  1'b0, 32'h0000_00ff, 32'h0000_0001},  // carry out, zero
      '{ialu_pkg::FUNC_ADD,  1'b0, 32'h0000_007f, 32'h0000_0001},  // byte overflow
      '{ialu_pkg::FUNC_ADD,  1'b1, 32'hffff_ffff, 32'h0000_0001},
      '{ialu_pkg::FUNC_ADD,  1'b1, 32'h7fff_ffff, 32'h0000_0001},
      '{ialu_pkg::FUNC_SUB,  1'b0, 32'h0000_0000, 32'h0000_0001},  // borrow
      '{ialu_pkg::FUNC_SUB,  1'b0, 32'h0000_0080, 32'h0000_0001},
      '{ialu_pkg::FUNC_SUB,  1'b1, 32'h8000_0000, 32'h0000_0001},
      '{ialu_pkg::FUNC_CMP,  1'b1, 32'h0000_1234, 32'h0000_1234},
      '{ialu_pkg::FUNC_CMP,  1'b0, 32'hffff_ff00, 32'h0000_00ff},  // upper bits ignored
      '{ialu_pkg::FUNC_AND,  1'b1, 32'hffff_ffff, 32'h8000_0000},
      '{ialu_pkg::FUNC_XOR,  1'b0, 32'h0000_00a5, 32'h0000_00a5},
      '{ialu_pkg::FUNC_TEST, 1'b1, 32'hf0f0_f0f0, 32'h0f0f_0f0f},
      '{ialu_pkg::FUNC_INC,  1'b0, 32'h0000_00ff, 32'h0000_0000},  // cf must survive
      '{ialu_pkg::FUNC_INC,  1'b1, 32'h7fff_ffff, 32'h0000_0000},
      '{ialu_pkg::FUNC_DEC,  1'b0, 32'h0000_0000, 32'h0000_0000},
      '{ialu_pkg::FUNC_DEC,  1'b1, 32'h8000_0000, 32'h0000_0000},
      '{ialu_pkg::FUNC_SAR,  1'b1, 32'h8000_0000, 32'h0000_0000},  // zero count
      '{ialu_pkg::FUNC_SAR,  1'b0, 32'h0000_0081, 32'h0000_0001},
      '{ialu_pkg::FUNC_SAR,  1'b1, 32'h8000_0001, 32'h0000_001f},
      '{ialu_pkg::FUNC_SAR,  1'b0, 32'h0000_0080, 32'h0000_0008},  // byte shifted past width
      '{ialu_pkg::FUNC_SAR,  1'b0, 32'h0000_0040, 32'h0000_0009},
      '{ialu_pkg::FUNC_SAR,  1'b0, 32'h0000_00c0, 32'h0000_0007},
      '{ialu_pkg::FUNC_SAR,  1'b1, 32'h7fff_ffff, 32'hffff_ffe3},  // count from low bits
      '{FUNC_UNUSED_LO,      1'b1, 32'hdead_beef, 32'h0000_0000},
      '{FUNC_UNUSED_HI,      1'b0, 32'h0001_2345, 32'hffff_ffff}
    };
    foreach (directed_q[i]) send_word(directed_q[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // alternate stretches at full rate with stretches of random gaps
      if (i % 250 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_word(rand_word());
    end
    quiet = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[integer_alu_with_status_flags_unit] OK");
    end else begin
      $display("[integer_alu_with_status_flags_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ integer_alu_with_status_flags_unit.f @@
+incdir+rtl
rtl/ialu_pkg.sv
rtl/ialu_in_if.sv
rtl/ialu_out_if.sv
rtl/ialu_core.sv
rtl/integer_alu_with_status_flags_unit.sv
rtl/ialu_checker.sv
verif/tb_top.sv
